### design/lmsd_pkg.sv
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types and constants for the LED matrix scan driver: panel geometry,
// item and result structs, action and register codes, scan phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsd_pkg;

    localparam int WIDTH_PIXELS  = 32;
    localparam int HEIGHT_PIXELS = 32;
    localparam int SCAN_ROWS     = 16;
    localparam int ROW_W         = 4;
    localparam int COL_W         = (WIDTH_PIXELS > 1) ? $clog2(WIDTH_PIXELS) : 1;
    // one word per (scan row, column): top pixel in [2:0], bottom pixel in [5:3]
    localparam int FB_AW         = ROW_W + COL_W;
    localparam int FB_DEPTH      = 1 << FB_AW;

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd1;
    localparam logic [15:0] DWELL_RESET       = 16'd200;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL       = 2'd1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        PH_SETUP = 4'b0001,
        PH_CLOCK = 4'b0010,
        PH_LATCH = 4'b0100,
        PH_DWELL = 4'b1000
    } t_phase;

    typedef struct packed {
        t_action     action;
        logic [5:0]  x_position;
        logic [5:0]  y_position;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
    } t_in_item;

    typedef struct packed {
        logic        top_red;
        logic        top_green;
        logic        top_blue;
        logic        bottom_red;
        logic        bottom_green;
        logic        bottom_blue;
        logic        shift_clock;
        logic        latch_pulse;
        logic        output_disable;
        logic [3:0]  row_address;
    } t_out_item;

    localparam t_out_item PINS_RESET = '{
        top_red: 1'b0, top_green: 1'b0, top_blue: 1'b0,
        bottom_red: 1'b0, bottom_green: 1'b0, bottom_blue: 1'b0,
        shift_clock: 1'b0, latch_pulse: 1'b0, output_disable: 1'b1,
        row_address: 4'd0
    };

    typedef struct packed {
        logic             rd_en;
        logic [FB_AW-1:0] rd_addr;
        logic             wr_en;       // merge into the word read last
        logic             wr_bottom;
        logic [2:0]       wr_rgb;
        logic             clear_start;
    } t_fb_req;

endpackage

`default_nettype wire

### design/lmsd_fb.sv
// ----------------------------------------------------------------------------
// lmsd_fb
// Frame buffer: synchronous RAM with registered read, read-modify-write of a
// half word for pixel writes, and a clearing sweep after reset or on request.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsd_fb
    import lmsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fb_req    i_req,
    output logic [5:0] o_rd_data,
    output logic       o_clr_busy
);

    logic [5:0]       r_mem [FB_DEPTH];
    logic [5:0]       r_rd_data;
    logic [FB_AW-1:0] r_rd_addr;
    logic             r_clr_active, n_clr_active;
    logic [FB_AW-1:0] r_clr_addr, n_clr_addr;
    logic [5:0]       merged;

    assign merged = i_req.wr_bottom ? {i_req.wr_rgb, r_rd_data[2:0]}
                                    : {r_rd_data[5:3], i_req.wr_rgb};

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= 6'd0;
        end else if (i_req.wr_en) begin
            r_mem[r_rd_addr] <= merged;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    always_comb begin
        n_clr_active = r_clr_active;
        n_clr_addr   = r_clr_addr;
        if (r_clr_active) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == FB_AW'(FB_DEPTH - 1)) begin
                n_clr_active = 1'b0;
            end
        end else if (i_req.clear_start) begin
            n_clr_active = 1'b1;
            n_clr_addr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_clr_active <= n_clr_active;
            r_clr_addr   <= n_clr_addr;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_active;

endmodule

`default_nettype wire

### design/lmsd_scan.sv
// ----------------------------------------------------------------------------
// lmsd_scan
// Scan sequencer: row, column, phase and tick counter, and the pin register
// driven to the panel on each tick.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsd_scan
    import lmsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic [5:0]       i_pixels,
    input  logic [7:0]       i_half_period,
    input  logic [15:0]      i_dwell,
    output t_out_item        o_pins,
    output logic [FB_AW-1:0] o_rd_addr
);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_count, n_count;
    t_out_item        r_pins, n_pins;

    logic [5:0]       data;
    logic [15:0]      len;
    logic [15:0]      count_inc;
    logic [COL_W:0]   col_inc;

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_phase = r_phase;
        n_count = r_count;
        n_pins  = r_pins;

        data = {r_pins.bottom_blue, r_pins.bottom_green, r_pins.bottom_red,
                r_pins.top_blue, r_pins.top_green, r_pins.top_red};
        // data pins load on the first tick of a column's setup
        if (r_phase == PH_SETUP && r_count == 16'd0) begin
            data = i_pixels;
        end

        len = (r_phase == PH_DWELL) ? i_dwell : {8'd0, i_half_period};
        if (len == 16'd0) begin
            len = 16'd1;
        end
        count_inc = r_count + 16'd1;
        col_inc   = {1'b0, r_col} + 1'b1;

        if (i_tick) begin
            n_pins.top_red        = data[0];
            n_pins.top_green      = data[1];
            n_pins.top_blue       = data[2];
            n_pins.bottom_red     = data[3];
            n_pins.bottom_green   = data[4];
            n_pins.bottom_blue    = data[5];
            n_pins.shift_clock    = 1'b0;
            n_pins.latch_pulse    = 1'b0;
            n_pins.output_disable = 1'b1;
            unique case (r_phase)
                PH_SETUP: ;
                PH_CLOCK: n_pins.shift_clock = 1'b1;
                PH_LATCH: n_pins.latch_pulse = 1'b1;
                PH_DWELL: begin
                    n_pins.output_disable = 1'b0;
                    n_pins.row_address    = r_row;
                end
                default: ;
            endcase

            n_count = count_inc;
            // >= also ends a phase cut short by a lowered register
            if (count_inc >= len) begin
                n_count = 16'd0;
                unique case (r_phase)
                    PH_SETUP: n_phase = PH_CLOCK;
                    PH_CLOCK: begin
                        if (col_inc >= (COL_W + 1)'(WIDTH_PIXELS)) begin
                            n_col   = '0;
                            n_phase = PH_LATCH;
                        end else begin
                            n_col   = col_inc[COL_W-1:0];
                            n_phase = PH_SETUP;
                        end
                    end
                    PH_LATCH: n_phase = PH_DWELL;
                    PH_DWELL: begin
                        n_row   = r_row + 1'b1;
                        n_col   = '0;
                        n_phase = PH_SETUP;
                    end
                    default: n_phase = PH_SETUP;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_phase <= PH_SETUP;
            r_count <= 16'd0;
            r_pins  <= PINS_RESET;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_phase <= n_phase;
            r_count <= n_count;
            r_pins  <= n_pins;
        end
    end

    assign o_pins    = r_pins;
    assign o_rd_addr = {r_row, r_col};

endmodule

`default_nettype wire

### design/led_matrix_scan_driver.sv
// ----------------------------------------------------------------------------
// led_matrix_scan_driver
// 1:16 scan LED matrix driver with a one-bit-per-color frame buffer.
// ----------------------------------------------------------------------------
// Each item is transferred and then executed: the transfer cycle issues the
// frame-buffer read, the next cycle (busy high) applies the tick or the pixel
// write using the registered read data of the frame-buffer RAM. The result
// strobe follows in the cycle after and cannot be stalled; a new item may
// be transferred in that same cycle. After reset and after a clear item the
// frame buffer is swept to zero, one word a cycle over all 16 * 2^COL_W words
// (512 for a 32-wide panel), with busy high; configuration writes are always
// taken (ready is tied high) and should be made only while idle.
`default_nettype none

module led_matrix_scan_driver
    import lmsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output t_out_item            o_result,
    output logic                 o_result_valid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic        r_result_valid;
    logic [7:0]  r_half_period, n_half_period;
    logic [15:0] r_dwell, n_dwell;

    logic             accept;
    logic             exec;
    logic             clr_busy;
    logic             in_range;
    logic [5:0]       rd_data;
    logic [FB_AW-1:0] scan_addr;
    t_fb_req          fb_req;

    assign exec        = (r_state == S_EXEC);
    assign busy        = exec | clr_busy;
    assign accept      = start & ~busy;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_comb begin
        n_half_period = r_half_period;
        n_dwell       = r_dwell;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: n_half_period = i_cfg_data[7:0];
                CFG_DWELL:       n_dwell       = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result_valid <= 1'b0;
            r_half_period  <= HALF_PERIOD_RESET;
            r_dwell        <= DWELL_RESET;
        end else begin
            r_state        <= n_state;
            r_result_valid <= exec;
            r_half_period  <= n_half_period;
            r_dwell        <= n_dwell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign in_range = ({1'b0, r_item.x_position} < 7'(WIDTH_PIXELS)) &&
                      ({1'b0, r_item.y_position} < 7'(HEIGHT_PIXELS));

    always_comb begin
        fb_req.rd_en       = accept;
        fb_req.rd_addr     = (i_item.action == ACT_SET)
                           ? {i_item.y_position[ROW_W-1:0], i_item.x_position[COL_W-1:0]}
                           : scan_addr;
        fb_req.wr_en       = exec && (r_item.action == ACT_SET) && in_range;
        // rows 16 and up sit in the upper half of the word
        fb_req.wr_bottom   = r_item.y_position[4];
        fb_req.wr_rgb      = {r_item.blue_level != 8'd0, r_item.green_level != 8'd0,
                              r_item.red_level != 8'd0};
        fb_req.clear_start = exec && (r_item.action == ACT_CLEAR);
    end

    lmsd_fb u_fb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (fb_req),
        .o_rd_data  (rd_data),
        .o_clr_busy (clr_busy)
    );

    lmsd_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (exec && (r_item.action == ACT_TICK)),
        .i_pixels      (rd_data),
        .i_half_period (r_half_period),
        .i_dwell       (r_dwell),
        .o_pins        (o_result),
        .o_rd_addr     (scan_addr)
    );

    assign o_result_valid = r_result_valid;

    // a result strobe comes only in the cycle after an executed item
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without an executed item");

    // a clear item hands straight over to the sweep
    a_clear_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && r_item.action == ACT_CLEAR) |=> busy)
        else $error("busy dropped after clear item");

    // panel is lit only with clock and latch low
    a_dwell_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.output_disable) |->
            (!o_result.shift_clock && !o_result.latch_pulse))
        else $error("clock or latch high while output enabled");

endmodule

`default_nettype wire
